// ===== rtl/bect_pkg.sv =====
// bect_pkg: shared types, codes and constants of the binary edge contour tracer
// no dependencies; imported by every module of the block except bect_ram

package bect_pkg;

    localparam int MAX_WIDTH_DEF  = 512;
    localparam int MAX_HEIGHT_DEF = 512;
    localparam int MAX_POINTS_DEF = 4096;

    localparam int CFG_DW     = 10;
    localparam int COORD_W    = 9;
    localparam int NB_COUNT   = 8;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_RESTART = 2'd1,
        OP_FETCH   = 2'd2
    } op_t;

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_EVAL,
        ST_NB,
        ST_NB_EVAL,
        ST_EMIT_PT,
        ST_EMIT_DONE
    } state_t;

    typedef struct packed {
        logic clr_step;
        logic pix_wr;
        logic restart;
        logic buf_rd;
        logic out_load;
        logic out_done;
        logic scan_wrap;
        logic scan_rd;
        logic scan_adv;
        logic trace_start;
        logic nb_skip;
        logic nb_rd;
        logic nb_move;
        logic dead_turn;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic rd_lt_cnt;
        logic scan_y_end;
        logic scan_x_end;
        logic hit;
        logic nb_in;
        logic k_end;
        logic second;
        logic out_free;
    } sts_t;

    // neighbor order: up, down, left, right, up-left, up-right, down-left, down-right
    function automatic logic signed [1:0] nb_dx(input logic [2:0] k);
        logic signed [1:0] d;
        case (k)
            3'd0, 3'd1:       d = 2'sd0;
            3'd2, 3'd4, 3'd6: d = -2'sd1;
            default:          d = 2'sd1;
        endcase
        return d;
    endfunction

    function automatic logic signed [1:0] nb_dy(input logic [2:0] k);
        logic signed [1:0] d;
        case (k)
            3'd0, 3'd4, 3'd5: d = -2'sd1;
            3'd2, 3'd3:       d = 2'sd0;
            default:          d = 2'sd1;
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/bect_if.sv =====
// bect_req_if / bect_rsp_if: valid-ready channels of the contour tracer
// depends on bect_pkg

interface bect_req_if import bect_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [1:0]           operation;
    logic [COORD_W-1:0]   pixel_x;
    logic [COORD_W-1:0]   pixel_y;
    logic                 pixel_value;

    modport source (output valid, operation, pixel_x, pixel_y, pixel_value, input ready);
    modport sink   (input valid, operation, pixel_x, pixel_y, pixel_value, output ready);
endinterface

interface bect_rsp_if import bect_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [COORD_W-1:0]   point_x;
    logic [COORD_W-1:0]   point_y;
    logic                 first_of_contour;
    logic                 last_of_contour;
    logic                 frame_done;
    logic                 overflow;

    modport source (output valid, point_x, point_y, first_of_contour, last_of_contour,
                    frame_done, overflow, input ready);
    modport sink   (input valid, point_x, point_y, first_of_contour, last_of_contour,
                    frame_done, overflow, output ready);
endinterface

// ===== rtl/bect_ram.sv =====
// bect_ram: generic one-write one-read memory with registered read data
// no dependencies

module bect_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/bect_ctrl.sv =====
// bect_ctrl: sequencer of the contour tracer (clear, scan, trace, emit)
// depends on bect_pkg; drives the datapath through cmd_t, reads sts_t

module bect_ctrl import bect_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_op,
    output logic       in_ready,
    input  sts_t       sts,
    output cmd_t       cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_op)
                        OP_RESTART: state_next = ST_CLEAR;
                        OP_FETCH:   state_next = sts.rd_lt_cnt ? ST_EMIT_PT : ST_SCAN;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_y_end)
                begin
                    state_next = ST_EMIT_DONE;
                end
                else if (!sts.scan_x_end)
                begin
                    state_next = ST_SCAN_EVAL;
                end
            end
            ST_SCAN_EVAL:
            begin
                state_next = sts.hit ? ST_NB : ST_SCAN;
            end
            ST_NB:
            begin
                if (sts.k_end)
                begin
                    if (sts.second)
                    begin
                        state_next = ST_EMIT_PT;
                    end
                end
                else if (sts.nb_in)
                begin
                    state_next = ST_NB_EVAL;
                end
            end
            ST_NB_EVAL:
            begin
                state_next = ST_NB;
            end
            ST_EMIT_PT, ST_EMIT_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (in_op)
                        OP_WRITE:   cmd.pix_wr  = 1'b1;
                        OP_RESTART: cmd.restart = 1'b1;
                        OP_FETCH:   cmd.buf_rd  = sts.rd_lt_cnt;
                        default:    cmd.pix_wr  = 1'b0;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (!sts.scan_y_end)
                begin
                    cmd.scan_wrap = sts.scan_x_end;
                    cmd.scan_rd   = !sts.scan_x_end;
                end
            end
            ST_SCAN_EVAL:
            begin
                cmd.scan_adv    = 1'b1;
                cmd.trace_start = sts.hit;
            end
            ST_NB:
            begin
                if (sts.k_end)
                begin
                    cmd.buf_rd    = sts.second;
                    cmd.dead_turn = !sts.second;
                end
                else
                begin
                    cmd.nb_rd   = sts.nb_in;
                    cmd.nb_skip = !sts.nb_in;
                end
            end
            ST_NB_EVAL:
            begin
                cmd.nb_move = sts.hit;
                cmd.nb_skip = !sts.hit;
            end
            ST_EMIT_PT:
            begin
                cmd.out_load = sts.out_free;
            end
            ST_EMIT_DONE:
            begin
                cmd.out_done = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/bect_dp.sv =====
// bect_dp: datapath of the contour tracer: pixel and visited memories, scan and
// trace registers, contour ring buffer and result register; depends on bect_pkg, bect_ram

module bect_dp import bect_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output sts_t                sts,
    input  logic [CFG_DW-1:0]   cfg_w,
    input  logic [CFG_DW-1:0]   cfg_h,
    input  logic [COORD_W-1:0]  pixel_x,
    input  logic [COORD_W-1:0]  pixel_y,
    input  logic                pixel_value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [COORD_W-1:0]  point_x,
    output logic [COORD_W-1:0]  point_y,
    output logic                first_of_contour,
    output logic                last_of_contour,
    output logic                frame_done,
    output logic                overflow
);

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int XW1 = $clog2(MAX_WIDTH + 1);
    localparam int YW1 = $clog2(MAX_HEIGHT + 1);
    localparam int AW  = XW + YW;
    localparam int PW  = $clog2(MAX_POINTS);
    localparam int CW  = $clog2(MAX_POINTS + 1);

    logic [XW1-1:0] scan_x_reg, scan_x_next;
    logic [YW1-1:0] scan_y_reg, scan_y_next;
    logic [XW-1:0]  cur_x_reg, cur_x_next, start_x_reg, start_x_next;
    logic [YW-1:0]  cur_y_reg, cur_y_next, start_y_reg, start_y_next;
    logic [3:0]     k_reg, k_next;
    logic           second_reg, second_next;
    logic [PW-1:0]  head_reg, head_next, tail_reg, tail_next;
    logic [CW-1:0]  count_reg, count_next, rd_idx_reg, rd_idx_next;
    logic           ovf_reg, ovf_next;
    logic [AW-1:0]  clr_cnt_reg;

    logic               ov_reg;
    logic [COORD_W-1:0] ox_reg, oy_reg;
    logic               ofirst_reg, olast_reg, odone_reg, oovf_reg;

    logic [XW1-1:0] eff_w;
    logic [YW1-1:0] eff_h;
    logic [XW1:0]   nxe;
    logic [YW1:0]   nye;
    logic [XW-1:0]  nx;
    logic [YW-1:0]  ny;

    logic           map_rd;
    logic [AW-1:0]  map_rd_addr;
    logic           edge_wr;
    logic           edge_bit, vis_bit;
    logic           vis_wr, vis_data;
    logic [AW-1:0]  vis_wr_addr;

    logic           add_pt, prepend, full;
    logic [XW-1:0]  add_x;
    logic [YW-1:0]  add_y;
    logic [PW-1:0]  tail_inc, head_dec;
    logic           buf_wr;
    logic [PW-1:0]  buf_wr_addr, buf_rd_addr;
    logic [PW:0]    rd_sum;
    logic [AW-1:0]  buf_rd_data;
    logic           out_free;

    // clamp the size registers to the memory; a zero size counts as one
    always_comb
    begin
        if (cfg_w == '0)
        begin
            eff_w = XW1'(1);
        end
        else if (32'(cfg_w) > MAX_WIDTH)
        begin
            eff_w = XW1'(MAX_WIDTH);
        end
        else
        begin
            eff_w = XW1'(cfg_w);
        end
        if (cfg_h == '0)
        begin
            eff_h = YW1'(1);
        end
        else if (32'(cfg_h) > MAX_HEIGHT)
        begin
            eff_h = YW1'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = YW1'(cfg_h);
        end
    end

    // a step below zero wraps to all ones and fails the bound compare
    assign nxe = {1'b0, XW1'(cur_x_reg)} + (XW1 + 1)'(nb_dx(k_reg[2:0]));
    assign nye = {1'b0, YW1'(cur_y_reg)} + (YW1 + 1)'(nb_dy(k_reg[2:0]));
    assign nx  = nxe[XW-1:0];
    assign ny  = nye[YW-1:0];

    assign map_rd      = cmd.scan_rd | cmd.nb_rd;
    assign map_rd_addr = cmd.nb_rd ? {ny, nx} : {YW'(scan_y_reg), XW'(scan_x_reg)};
    assign edge_wr     = cmd.pix_wr && (32'(pixel_x) < MAX_WIDTH) && (32'(pixel_y) < MAX_HEIGHT);

    bect_ram #(.WIDTH(1), .DEPTH(1 << AW)) u_edge (
        .clk     (clk),
        .wr_en   (edge_wr),
        .wr_addr ({YW'(pixel_y), XW'(pixel_x)}),
        .wr_data (pixel_value),
        .rd_en   (map_rd),
        .rd_addr (map_rd_addr),
        .rd_data (edge_bit)
    );

    always_comb
    begin
        vis_wr      = cmd.clr_step | cmd.trace_start | cmd.nb_move | cmd.dead_turn;
        vis_data    = !cmd.clr_step;
        vis_wr_addr = {start_y_reg, start_x_reg};
        if (cmd.clr_step)
        begin
            vis_wr_addr = clr_cnt_reg;
        end
        else if (cmd.trace_start)
        begin
            vis_wr_addr = {YW'(scan_y_reg), XW'(scan_x_reg)};
        end
        else if (cmd.nb_move)
        begin
            vis_wr_addr = {ny, nx};
        end
    end

    bect_ram #(.WIDTH(1), .DEPTH(1 << AW)) u_visited (
        .clk     (clk),
        .wr_en   (vis_wr),
        .wr_addr (vis_wr_addr),
        .wr_data (vis_data),
        .rd_en   (map_rd),
        .rd_addr (map_rd_addr),
        .rd_data (vis_bit)
    );

    // contour ring buffer
    assign add_pt   = cmd.nb_move | cmd.dead_turn;
    assign prepend  = cmd.dead_turn | (cmd.nb_move & second_reg);
    assign add_x    = cmd.nb_move ? nx : start_x_reg;
    assign add_y    = cmd.nb_move ? ny : start_y_reg;
    assign full     = (count_reg == CW'(MAX_POINTS));
    assign tail_inc = (tail_reg == PW'(MAX_POINTS - 1)) ? '0 : tail_reg + PW'(1);
    assign head_dec = (head_reg == '0) ? PW'(MAX_POINTS - 1) : head_reg - PW'(1);
    assign buf_wr   = cmd.trace_start | (add_pt & !full);

    always_comb
    begin
        buf_wr_addr = tail_reg;
        if (cmd.trace_start)
        begin
            buf_wr_addr = '0;
        end
        else if (prepend)
        begin
            buf_wr_addr = head_dec;
        end
    end

    assign rd_sum      = {1'b0, head_reg} + (PW + 1)'(rd_idx_reg);
    assign buf_rd_addr = (rd_sum >= (PW + 1)'(MAX_POINTS)) ?
                         PW'(rd_sum - (PW + 1)'(MAX_POINTS)) : PW'(rd_sum);

    bect_ram #(.WIDTH(AW), .DEPTH(MAX_POINTS)) u_buf (
        .clk     (clk),
        .wr_en   (buf_wr),
        .wr_addr (buf_wr_addr),
        .wr_data (cmd.trace_start ? {YW'(scan_y_reg), XW'(scan_x_reg)} : {add_y, add_x}),
        .rd_en   (cmd.buf_rd),
        .rd_addr (buf_rd_addr),
        .rd_data (buf_rd_data)
    );

    always_comb
    begin
        scan_x_next  = scan_x_reg;
        scan_y_next  = scan_y_reg;
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        start_x_next = start_x_reg;
        start_y_next = start_y_reg;
        k_next       = k_reg;
        second_next  = second_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        rd_idx_next  = rd_idx_reg;
        ovf_next     = ovf_reg;

        if (cmd.restart)
        begin
            scan_x_next = '0;
            scan_y_next = '0;
        end
        if (cmd.scan_wrap)
        begin
            scan_x_next = '0;
            scan_y_next = scan_y_reg + YW1'(1);
        end
        if (cmd.scan_adv)
        begin
            scan_x_next = scan_x_reg + XW1'(1);
        end
        if (cmd.restart || cmd.out_done)
        begin
            head_next   = '0;
            tail_next   = '0;
            count_next  = '0;
            rd_idx_next = '0;
            ovf_next    = 1'b0;
        end
        if (cmd.trace_start)
        begin
            start_x_next = XW'(scan_x_reg);
            start_y_next = YW'(scan_y_reg);
            cur_x_next   = XW'(scan_x_reg);
            cur_y_next   = YW'(scan_y_reg);
            k_next       = '0;
            second_next  = 1'b0;
            head_next    = '0;
            tail_next    = PW'(1);
            count_next   = CW'(1);
            rd_idx_next  = '0;
            ovf_next     = 1'b0;
        end
        if (cmd.nb_skip)
        begin
            k_next = k_reg + 4'd1;
        end
        if (cmd.nb_move)
        begin
            cur_x_next = nx;
            cur_y_next = ny;
            k_next     = '0;
        end
        if (cmd.dead_turn)
        begin
            cur_x_next  = start_x_reg;
            cur_y_next  = start_y_reg;
            k_next      = '0;
            second_next = 1'b1;
        end
        if (add_pt)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CW'(1);
                if (prepend)
                begin
                    head_next = head_dec;
                end
                else
                begin
                    tail_next = tail_inc;
                end
            end
        end
        if (cmd.out_load)
        begin
            rd_idx_next = rd_idx_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_x_reg  <= '0;
            scan_y_reg  <= '0;
            k_reg       <= '0;
            second_reg  <= 1'b0;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            rd_idx_reg  <= '0;
            ovf_reg     <= 1'b0;
            clr_cnt_reg <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            scan_x_reg <= scan_x_next;
            scan_y_reg <= scan_y_next;
            k_reg      <= k_next;
            second_reg <= second_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            rd_idx_reg <= rd_idx_next;
            ovf_reg    <= ovf_next;
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.out_load || cmd.out_done)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg   <= cur_x_next;
        cur_y_reg   <= cur_y_next;
        start_x_reg <= start_x_next;
        start_y_reg <= start_y_next;
        if (cmd.out_load)
        begin
            ox_reg     <= COORD_W'(buf_rd_data[XW-1:0]);
            oy_reg     <= COORD_W'(buf_rd_data[AW-1:XW]);
            ofirst_reg <= (rd_idx_reg == '0);
            olast_reg  <= (rd_idx_reg + CW'(1) == count_reg);
            odone_reg  <= 1'b0;
            oovf_reg   <= ovf_reg;
        end
        else if (cmd.out_done)
        begin
            ox_reg     <= '0;
            oy_reg     <= '0;
            ofirst_reg <= 1'b0;
            olast_reg  <= 1'b0;
            odone_reg  <= 1'b1;
            oovf_reg   <= 1'b0;
        end
    end

    assign out_free = !ov_reg || out_ready;

    assign sts.clr_last   = &clr_cnt_reg;
    assign sts.rd_lt_cnt  = rd_idx_reg < count_reg;
    assign sts.scan_y_end = scan_y_reg >= eff_h;
    assign sts.scan_x_end = scan_x_reg >= eff_w;
    assign sts.hit        = edge_bit & !vis_bit;
    assign sts.nb_in      = (nxe < {1'b0, eff_w}) && (nye < {1'b0, eff_h});
    assign sts.k_end      = (k_reg == 4'(NB_COUNT));
    assign sts.second     = second_reg;
    assign sts.out_free   = out_free;

    assign out_valid        = ov_reg;
    assign point_x          = ox_reg;
    assign point_y          = oy_reg;
    assign first_of_contour = ofirst_reg;
    assign last_of_contour  = olast_reg;
    assign frame_done       = odone_reg;
    assign overflow         = oovf_reg;

endmodule

// ===== rtl/binary_edge_contour_tracer.sv =====
// binary_edge_contour_tracer: top level with the size registers on an APB port
// depends on bect_pkg, bect_if, bect_ctrl, bect_dp

// The block holds a binary edge map of MAX_WIDTH by MAX_HEIGHT pixels and hands
// out contours one point per fetch word. A write word stores one pixel. A restart
// word clears the scan position and the contour buffer and then sweeps the visited
// map one entry a cycle; the same sweep runs after reset, and the block takes no
// word during it. A fetch whose point is already buffered reads it from the ring
// buffer and puts it into the output register once that is free. Otherwise the
// block scans the map from its scan position in raster order, reading and then
// evaluating each pixel, then traces the contour found: a neighbor outside the
// image is skipped, and each neighbor inside is probed by a read of the pixel and
// visited memories. Up to MAX_POINTS points of a contour are kept in a ring buffer;
// a longer contour is truncated and flags overflow on each of its points. The size
// registers sit at byte addresses 0 (width) and 4 (height) and may only be
// written while no fetch is in flight. A result waits in an output register, so
// a new word is taken while the previous result is still pending.

module binary_edge_contour_tracer import bect_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    bect_req_if.sink          req,
    bect_rsp_if.source        rsp
);

    logic [CFG_DW-1:0] width_reg;
    logic [CFG_DW-1:0] height_reg;
    logic              cfg_wr;
    cmd_t              cmd;
    sts_t              sts;

    // register file; the word address picks the register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_DW'(512);
            height_reg <= CFG_DW'(512);
        end
        else if (cfg_wr)
        begin
            case (reg_idx_t'(paddr[2]))
                REG_WIDTH:  width_reg  <= pwdata[CFG_DW-1:0];
                REG_HEIGHT: height_reg <= pwdata[CFG_DW-1:0];
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[2]))
            REG_WIDTH:  prdata = APB_DW'(width_reg);
            REG_HEIGHT: prdata = APB_DW'(height_reg);
            default:    prdata = '0;
        endcase
    end

    // sequencer: one word at a time, ready only when idle
    bect_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_op    (req.operation),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // memories, scan and trace registers, ring buffer, result register
    bect_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .cfg_w            (width_reg),
        .cfg_h            (height_reg),
        .pixel_x          (req.pixel_x),
        .pixel_y          (req.pixel_y),
        .pixel_value      (req.pixel_value),
        .out_valid        (rsp.valid),
        .out_ready        (rsp.ready),
        .point_x          (rsp.point_x),
        .point_y          (rsp.point_y),
        .first_of_contour (rsp.first_of_contour),
        .last_of_contour  (rsp.last_of_contour),
        .frame_done       (rsp.frame_done),
        .overflow         (rsp.overflow)
    );

endmodule

// ===== rtl/bect_checker.sv =====
// bect_props: port-level assertions of the contour tracer and their bind
// depends on bect_pkg and binary_edge_contour_tracer

module bect_props import bect_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic [1:0]         req_op,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic [COORD_W-1:0] rsp_x,
    input logic [COORD_W-1:0] rsp_y,
    input logic               rsp_first,
    input logic               rsp_last,
    input logic               rsp_done,
    input logic               rsp_ovf
);

    // a pending result stays until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    // frame done carries an empty point
    a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_done |-> rsp_x == '0 && rsp_y == '0 && !rsp_first
                                  && !rsp_last && !rsp_ovf)
        else $error("frame done with point data");

    // a contour holds its start twice, so no point is both first and last
    a_contour_len: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_first |-> !rsp_last)
        else $error("single point contour");

    // fetch and restart leave the block busy in the cycle after they are taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_op == OP_FETCH || req_op == OP_RESTART)
        |=> !req_ready)
        else $error("word taken while busy");

endmodule

bind binary_edge_contour_tracer bect_props u_bect_props (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_op    (req.operation),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_x     (rsp.point_x),
    .rsp_y     (rsp.point_y),
    .rsp_first (rsp.first_of_contour),
    .rsp_last  (rsp.last_of_contour),
    .rsp_done  (rsp.frame_done),
    .rsp_ovf   (rsp.overflow)
);

// ===== tb/sv/bect_checker.sv =====
// bect_checker: watches the request, response and apb channels of the contour tracer,
// predicts every response word and compares it; depends on bect_pkg and bect_if

module bect_checker import bect_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    input  logic              pready,
    bect_req_if               req,
    bect_rsp_if               rsp,
    output int                fail_count,
    output int                pending,
    output int                points_seen,
    output int                done_seen,
    output int                trunc_seen
);

    localparam int GRID_W   = 512;
    localparam int GRID_H   = 512;
    localparam int RING_LEN = 4096;
    localparam int STEP_DX [8] = '{0, 0, -1, 1, -1, 1, -1, 1};
    localparam int STEP_DY [8] = '{-1, 1, 0, 0, -1, -1, 1, 1};

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               first;
        logic               last;
        logic               done;
        logic               ovf;
    } point_word_t;

    point_word_t expected_points[$];

    bit                 edge_px [GRID_W*GRID_H];
    bit                 seen_px [GRID_W*GRID_H];
    logic [COORD_W-1:0] ring_x [RING_LEN];
    logic [COORD_W-1:0] ring_y [RING_LEN];
    int unsigned        head, tail, count, rd_idx;
    bit                 trunc;
    logic [CFG_DW-1:0]  width_reg, height_reg;
    int unsigned        scan_col, scan_row;

    function automatic int unsigned cols_in_use();
        return (width_reg < 1) ? 1 : (width_reg > GRID_W) ? GRID_W : width_reg;
    endfunction

    function automatic int unsigned rows_in_use();
        return (height_reg < 1) ? 1 : (height_reg > GRID_H) ? GRID_H : height_reg;
    endfunction

    function automatic void ring_reset();
        head = 0;
        tail = 0;
        count = 0;
        rd_idx = 0;
        trunc = 0;
    endfunction

    // queue an expected word at the back
    function automatic void expect_word(point_word_t p);
        expected_points = {expected_points, p};
    endfunction

    // front == 1 puts the point ahead of the list (second leg of the trace)
    function automatic void ring_put(int unsigned x, int unsigned y, bit front);
        if (count >= RING_LEN)
        begin
            trunc = 1;
            return;
        end
        if (front)
        begin
            head = (head == 0) ? RING_LEN - 1 : head - 1;
            ring_x[head] = COORD_W'(x);
            ring_y[head] = COORD_W'(y);
        end
        else
        begin
            ring_x[tail] = COORD_W'(x);
            ring_y[tail] = COORD_W'(y);
            tail = (tail + 1 >= RING_LEN) ? 0 : tail + 1;
        end
        count++;
    endfunction

    function automatic void follow_contour(int unsigned sx, int unsigned sy);
        int unsigned w, h, px, py;
        int          nx, ny;
        bit          second, moved;
        w = cols_in_use();
        h = rows_in_use();
        px = sx;
        py = sy;
        second = 0;
        ring_reset();
        seen_px[sy*GRID_W + sx] = 1;
        ring_put(sx, sy, 0);
        forever
        begin
            moved = 0;
            for (int k = 0; k < 8 && !moved; k++)
            begin
                nx = px + STEP_DX[k];
                ny = py + STEP_DY[k];
                if (nx >= 0 && ny >= 0 && nx < w && ny < h)
                begin
                    if (!seen_px[ny*GRID_W + nx] && edge_px[ny*GRID_W + nx])
                    begin
                        px = nx;
                        py = ny;
                        moved = 1;
                    end
                end
            end
            if (!moved)
            begin
                // dead end: go back to the start pixel, a second dead end closes the contour
                px = sx;
                py = sy;
                if (second)
                begin
                    return;
                end
                second = 1;
            end
            ring_put(px, py, second);
            seen_px[py*GRID_W + px] = 1;
        end
    endfunction

    function automatic bit find_start();
        int unsigned w, h, a;
        w = cols_in_use();
        h = rows_in_use();
        while (scan_row < h)
        begin
            if (scan_col >= w)
            begin
                scan_col = 0;
                scan_row++;
            end
            else
            begin
                a = scan_row*GRID_W + scan_col;
                scan_col++;
                if (edge_px[a] && !seen_px[a])
                begin
                    follow_contour(scan_col - 1, scan_row);
                    return 1;
                end
            end
        end
        return 0;
    endfunction

    function automatic void fetch_point();
        point_word_t p;
        int unsigned slot;
        p = '0;
        if (rd_idx >= count && !find_start())
        begin
            ring_reset();
            p.done = 1;
            expect_word(p);
            return;
        end
        slot = head + rd_idx;
        if (slot >= RING_LEN)
        begin
            slot -= RING_LEN;
        end
        p.x     = ring_x[slot];
        p.y     = ring_y[slot];
        p.first = (rd_idx == 0);
        p.last  = (rd_idx + 1 == count);
        p.ovf   = trunc;
        rd_idx++;
        expect_word(p);
    endfunction

    initial
    begin
        fail_count = 0;
        points_seen = 0;
        done_seen = 0;
        trunc_seen = 0;
        width_reg = CFG_DW'(512);
        height_reg = CFG_DW'(512);
        scan_col = 0;
        scan_row = 0;
        ring_reset();
    end

    assign pending = expected_points.size();

    always @(posedge clk)
    begin
        point_word_t got, want;
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (reg_idx_t'(paddr[2]) == REG_WIDTH)
                begin
                    width_reg = pwdata[CFG_DW-1:0];
                end
                else
                begin
                    height_reg = pwdata[CFG_DW-1:0];
                end
            end
            // a result never comes out in the cycle its fetch is taken, so check before predicting
            if (rsp.valid && rsp.ready)
            begin
                got = {rsp.point_x, rsp.point_y, rsp.first_of_contour, rsp.last_of_contour,
                       rsp.frame_done, rsp.overflow};
                if (expected_points.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected word %h", $time, got);
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (got.x !== want.x || got.y !== want.y || got.first !== want.first ||
                        got.last !== want.last || got.done !== want.done ||
                        got.ovf !== want.ovf)
                    begin
                        fail_count++;
                        $display("%0t: mismatch exp x=%0d y=%0d f=%b l=%b d=%b o=%b",
                                 $time, want.x, want.y, want.first, want.last, want.done,
                                 want.ovf);
                        $display("%0t:          act x=%0d y=%0d f=%b l=%b d=%b o=%b",
                                 $time, got.x, got.y, got.first, got.last, got.done, got.ovf);
                    end
                    if (want.done)
                    begin
                        done_seen++;
                    end
                    else
                    begin
                        points_seen++;
                    end
                    if (want.ovf)
                    begin
                        trunc_seen++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                case (req.operation)
                    OP_WRITE:
                    begin
                        edge_px[req.pixel_y*GRID_W + req.pixel_x] = req.pixel_value;
                    end
                    OP_RESTART:
                    begin
                        foreach (seen_px[i])
                        begin
                            seen_px[i] = 0;
                        end
                        scan_col = 0;
                        scan_row = 0;
                        ring_reset();
                    end
                    OP_FETCH:
                    begin
                        fetch_point();
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

endmodule

// ===== tb/sv/binary_edge_contour_tracer_tb.sv =====
// binary_edge_contour_tracer_tb: stimulus, clock, reset and verdict for the contour tracer
// depends on bect_pkg, bect_if, bect_checker and the block itself

module binary_edge_contour_tracer_tb;
    import bect_pkg::*;

    // during the clearing sweep after reset and after a restart the block takes no word
    localparam int IDLE_LIMIT   = 800000;
    localparam int GRID_W       = 512;
    localparam int RAND_PHASES  = 10;
    localparam int RAND_WORDS   = 60;

    logic              clk;
    logic              rst_n;
    logic              psel, penable, pwrite, pready;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata, prdata;

    bect_req_if req_ch ();
    bect_rsp_if rsp_ch ();

    int  fail_count, pending, points_seen, done_seen, trunc_seen;
    int  words_sent;
    int  burst_left;
    int  stall_left;
    int  idle_cycles;
    // pixels already written, so a scan never reads an undefined edge bit
    bit  filled [GRID_W*GRID_W];
    int  cols, rows;

    binary_edge_contour_tracer u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    bect_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .fail_count  (fail_count),
        .pending     (pending),
        .points_seen (points_seen),
        .done_seen   (done_seen),
        .trunc_seen  (trunc_seen)
    );

    initial clk = 0;
    always #5 clk = ~clk;

    // receiver: mostly ready, stalls of random length now and then
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            rsp_ch.ready = 0;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(1, 7);
            rsp_ch.ready = 0;
        end
        else
        begin
            rsp_ch.ready = 1;
        end
    end

    // watchdog: ends the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (psel && penable))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no traffic for %0d cycles, %0d words outstanding",
                     IDLE_LIMIT, pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // one word on the request channel; bursts with random gaps between them
    task automatic push_word(op_t op, int x, int y, bit v);
        if (burst_left == 0)
        begin
            req_ch.valid = 0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        req_ch.valid       = 1;
        req_ch.operation   = op;
        req_ch.pixel_x     = COORD_W'(x);
        req_ch.pixel_y     = COORD_W'(y);
        req_ch.pixel_value = v;
        if (op == OP_WRITE)
        begin
            filled[y*GRID_W + x] = 1;
        end
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        words_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drain();
        req_ch.valid = 0;
        burst_left = 0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        // a trailing pixel write may still be in flight
        repeat (20) @(negedge clk);
        // a clearing sweep holds the block busy
        while (!req_ch.ready)
        begin
            @(negedge clk);
        end
    endtask

    task automatic apb_write(reg_idx_t idx, int value);
        psel    = 1;
        pwrite  = 1;
        penable = 0;
        paddr   = APB_AW'(int'(idx) * 4);
        pwdata  = APB_DW'(value);
        @(negedge clk);
        penable = 1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        psel    = 0;
        penable = 0;
    endtask

    // new size, applied while idle; fills every unwritten pixel of the new area
    task automatic set_size(int w, int h, int density);
        wait_drain();
        apb_write(REG_WIDTH, w);
        apb_write(REG_HEIGHT, h);
        cols = (w < 1) ? 1 : (w > GRID_W) ? GRID_W : w;
        rows = (h < 1) ? 1 : (h > GRID_W) ? GRID_W : h;
        for (int y = 0; y < rows; y++)
        begin
            for (int x = 0; x < cols; x++)
            begin
                if (!filled[y*GRID_W + x])
                begin
                    push_word(OP_WRITE, x, y, $urandom_range(0, 99) < density);
                end
            end
        end
    endtask

    task automatic random_words(int n);
        int r;
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
            begin
                push_word(op_t'(2'd3), $urandom_range(0, 511), $urandom_range(0, 511),
                          $urandom_range(0, 1) == 1);
            end
            else if (r < 45)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    push_word(OP_WRITE, $urandom_range(0, 511), $urandom_range(0, 511),
                              $urandom_range(0, 1) == 1);
                end
                else
                begin
                    push_word(OP_WRITE, $urandom_range(0, cols - 1),
                              $urandom_range(0, rows - 1), $urandom_range(0, 99) < 35);
                end
            end
            else
            begin
                push_word(OP_FETCH, 0, 0, 0);
            end
        end
    endtask

    initial
    begin
        rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        req_ch.valid = 0;
        req_ch.operation = OP_WRITE;
        req_ch.pixel_x = '0;
        req_ch.pixel_y = '0;
        req_ch.pixel_value = 0;
        rsp_ch.ready = 0;
        stall_left = 0;
        burst_left = 0;
        idle_cycles = 0;
        words_sent = 0;
        repeat (12) @(negedge clk);
        rst_n = 1;

        // directed: a contour of a three-pixel column with a pixel left of its middle, whose start point shows up twice
        set_size(4, 4, 0);
        push_word(OP_WRITE, 1, 0, 1);
        push_word(OP_WRITE, 1, 1, 1);
        push_word(OP_WRITE, 1, 2, 1);
        push_word(OP_WRITE, 0, 1, 1);
        push_word(OP_WRITE, 511, 511, 1);
        push_word(op_t'(2'd3), 511, 511, 1);
        repeat (7)
        begin
            push_word(OP_FETCH, 0, 0, 0);
        end
        // pause until every result is back before the restart
        wait_drain();
        push_word(OP_RESTART, 0, 0, 0);
        repeat (3)
        begin
            push_word(OP_FETCH, 0, 0, 0);
        end

        // random phases: size extremes first (with clamping), then small random sizes
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph)
                0:       set_size(1, 1, 60);
                1:       set_size(0, 6, 50);
                2:       set_size(1023, 1, 30);
                3:       set_size(512, 1, 40);
                4:       set_size(7, 0, 50);
                default: set_size($urandom_range(0, 16), $urandom_range(0, 16), 35);
            endcase
            random_words(RAND_WORDS);
        end

        wait_drain();
        repeat (50) @(negedge clk);
        $display("covered %0d words: %0d contour points, %0d frame ends, %0d truncated points",
                 words_sent, points_seen, done_seen, trunc_seen);
        if (fail_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
